// File: design/tanh_table_hermite_interp_assert.svh
// assertion macros for the tanh hermite interpolator
`ifndef TANH_TABLE_HERMITE_INTERP_ASSERT_SVH
`define TANH_TABLE_HERMITE_INTERP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TTHI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TTHI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tthi_pkg.sv
// constants, types and rom builder functions for the tanh hermite interpolator
package tthi_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int FRAC_BITS     = 14;
  localparam int ROM_BITS      = 30;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int SAT_ONE  = 16384;
  localparam int IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int VAL_W    = ROM_BITS + 1;
  localparam int SLOPE_W  = ROM_BITS + 3 - $clog2(TABLE_ENTRIES - 1);
  localparam int POS_W    = IN_W + IDX_W;
  localparam int P_W      = POS_W + FRAC_BITS;
  localparam int T_W      = FRAC_BITS + 1;
  localparam int SQ_W     = 2 * FRAC_BITS + 1;
  localparam int H_W      = FRAC_BITS + 2;
  localparam int PROD_W   = H_W + VAL_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int OUT_SHIFT = FRAC_BITS + 16;
  localparam int RES_W    = ACC_W - OUT_SHIFT;

  localparam logic [63:0] ROM_ONE = 64'd1 << ROM_BITS;

  typedef logic signed [IN_W-1:0]    in_data_t;
  typedef logic signed [OUT_W-1:0]   out_data_t;
  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [SLOPE_W-1:0] slope_t;
  typedef val_t   val_rom_t   [TABLE_ENTRIES];
  typedef slope_t slope_rom_t [TABLE_ENTRIES];

  // unsigned quotient by shift and subtract, only evaluated while the roms are built
  function automatic logic [63:0] quot_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(y) in q30 by its power series
  function automatic logic [63:0] exp_q30(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    logic        done;
    sum  = ROM_ONE;
    term = ROM_ONE;
    done = 1'b0;
    for (int k = 1; k <= 64; k++) begin
      if (!done) begin
        term = quot_u64((term * y) >> ROM_BITS, 64'(k));
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  // |tanh(x_i)| in q30
  function automatic logic [63:0] tanh_mag(input int i);
    int          off;
    logic [63:0] mag;
    logic [63:0] y;
    logic [63:0] e;
    off = 2 * i - (TABLE_ENTRIES - 1);
    mag = 64'((off < 0) ? -off : off);
    y   = ((mag << 1) << ROM_BITS) / 64'(TABLE_ENTRIES - 1);
    e   = exp_q30(y);
    return quot_u64((e - ROM_ONE) << ROM_BITS, e + ROM_ONE);
  endfunction

  function automatic val_rom_t build_val_rom();
    val_rom_t    rom;
    logic [63:0] mag;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      mag    = tanh_mag(i);
      rom[i] = (2 * i < TABLE_ENTRIES - 1) ? -val_t'(mag) : val_t'(mag);
    end
    return rom;
  endfunction

  // (1 - tanh^2) scaled by the table step
  function automatic slope_rom_t build_slope_rom();
    slope_rom_t  rom;
    logic [63:0] mag;
    logic [63:0] q;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      mag = tanh_mag(i);
      q   = (mag * mag) >> ROM_BITS;
      if (q > ROM_ONE) begin
        q = ROM_ONE;
      end
      rom[i] = slope_t'((64'd2 * (ROM_ONE - q)) / 64'(TABLE_ENTRIES - 1));
    end
    return rom;
  endfunction

endpackage

// File: design/tthi_if.sv
// valid/ready channel interfaces for the tanh hermite interpolator
interface tthi_in_if;
  import tthi_pkg::*;
  logic     valid;
  logic     ready;
  in_data_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface tthi_out_if;
  import tthi_pkg::*;
  logic      valid;
  logic      ready;
  out_data_t tanh_out;
  modport source (output valid, output tanh_out, input ready);
  modport sink (input valid, input tanh_out, output ready);
endinterface

// File: design/tanh_table_hermite_interp.sv
// tanh of a q1.14 sample by cubic hermite interpolation between rom entries
// One transaction in gives one transaction out, q1.14 in -1..+1. The input is
// saturated to [-1,1], mapped onto a table of TABLE_ENTRIES evenly spaced
// points, and tanh is rebuilt from the two neighbouring entries of a value rom
// and a slope rom (slope already scaled by the table step) with the hermite
// basis in the fractional position. The block takes one sample every clock
// unless backpressure from the output reaches the input; it has eight register
// stages: position multiply, index/fraction split, rom read with squaring,
// rounding, basis multipliers, product multipliers and a two-level adder with
// final rounding and saturation. The roms are constants, so there is no
// start-up sweep after reset. Backpressure moves stage by stage: an empty
// stage keeps taking data even while a finished result waits at the output.
`include "tanh_table_hermite_interp_assert.svh"

module tanh_table_hermite_interp
  import tthi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tthi_in_if.sink    in_ch,
  tthi_out_if.source out_ch
);

  localparam int STAGES = 8;

  localparam val_rom_t   VAL_ROM   = build_val_rom();
  localparam slope_rom_t SLOPE_ROM = build_slope_rom();

  localparam logic [T_W-1:0]         FRAC_ONE  = T_W'(1) << FRAC_BITS;
  localparam logic [H_W-1:0]         THREE_ONE = H_W'(3) << FRAC_BITS;
  localparam logic [SQ_W:0]          RND_HALF  = (SQ_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_OUT  = ACC_W'(1) << (OUT_SHIFT - 1);

  // ---------------------------------------------------------------------------
  // stage control: valid bits ride with the data, a stage loads when it is
  // empty or the stage after it loads
  // ---------------------------------------------------------------------------
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES:0]   stage_en;

  always_comb begin
    stage_en[STAGES] = out_ch.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = stage_en[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < STAGES; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = stage_en[0];

  // ---------------------------------------------------------------------------
  // stage 0: saturate to [-1,1] and scale to table position (times N-1)
  // ---------------------------------------------------------------------------
  in_data_t          sat;
  logic [IN_W-1:0]   sat_ofs;
  logic [POS_W-1:0]  pos_r;

  always_comb begin
    if (in_ch.sample_in > in_data_t'(SAT_ONE)) begin
      sat = in_data_t'(SAT_ONE);
    end else if (in_ch.sample_in < -in_data_t'(SAT_ONE)) begin
      sat = -in_data_t'(SAT_ONE);
    end else begin
      sat = in_ch.sample_in;
    end
    // sat + 1.0 lands in 0..32768, fits unsigned
    sat_ofs = IN_W'(sat) + IN_W'(SAT_ONE);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pos_r <= POS_W'(sat_ofs) * POS_W'(TABLE_ENTRIES - 1);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: split position into clamped index and fraction t, u = 1 - t
  // ---------------------------------------------------------------------------
  logic [P_W-1:0]   p_full;
  logic [POS_W-1:0] idx_raw;
  logic [IDX_W-1:0] idx_c;
  logic [P_W-1:0]   p_diff;
  logic [T_W-1:0]   t_c;
  logic [IDX_W-1:0] idx1_r;
  logic [T_W-1:0]   t1_r;
  logic [T_W-1:0]   u1_r;

  always_comb begin
    p_full  = {pos_r, {FRAC_BITS{1'b0}}} >> (IN_W - 1);
    idx_raw = p_full[P_W-1:FRAC_BITS];
    // top of range (input +1) lands one past the last interval
    if (idx_raw > POS_W'(TABLE_ENTRIES - 2)) begin
      idx_c = IDX_W'(TABLE_ENTRIES - 2);
    end else begin
      idx_c = idx_raw[IDX_W-1:0];
    end
    p_diff = p_full - {POS_W'(idx_c), {FRAC_BITS{1'b0}}};
    if (p_diff > P_W'(FRAC_ONE)) begin
      t_c = FRAC_ONE;
    end else begin
      t_c = p_diff[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      idx1_r <= idx_c;
      t1_r   <= t_c;
      u1_r   <= FRAC_ONE - t_c;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: rom reads at idx and idx+1, squares of t and u
  // ---------------------------------------------------------------------------
  val_t            v0_r;
  val_t            v1_r;
  slope_t          d0_r;
  slope_t          d1_r;
  logic [SQ_W-1:0] uusq_r;
  logic [SQ_W-1:0] ttsq_r;
  logic [T_W-1:0]  t2_r;
  logic [T_W-1:0]  u2_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      v0_r   <= VAL_ROM[idx1_r];
      v1_r   <= VAL_ROM[idx1_r + IDX_W'(1)];
      d0_r   <= SLOPE_ROM[idx1_r];
      d1_r   <= SLOPE_ROM[idx1_r + IDX_W'(1)];
      uusq_r <= SQ_W'(u1_r) * SQ_W'(u1_r);
      ttsq_r <= SQ_W'(t1_r) * SQ_W'(t1_r);
      t2_r   <= t1_r;
      u2_r   <= u1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: round the squares back to the fraction format
  // ---------------------------------------------------------------------------
  logic [SQ_W:0]  uu_sum;
  logic [SQ_W:0]  tt_sum;
  logic [T_W-1:0] uu3_r;
  logic [T_W-1:0] tt3_r;
  logic [T_W-1:0] t3_r;
  logic [T_W-1:0] u3_r;
  val_t           v0_3_r;
  val_t           v1_3_r;
  slope_t         d0_3_r;
  slope_t         d1_3_r;

  always_comb begin
    uu_sum = {1'b0, uusq_r} + RND_HALF;
    tt_sum = {1'b0, ttsq_r} + RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      uu3_r  <= uu_sum[FRAC_BITS +: T_W];
      tt3_r  <= tt_sum[FRAC_BITS +: T_W];
      t3_r   <= t2_r;
      u3_r   <= u2_r;
      v0_3_r <= v0_r;
      v1_3_r <= v1_r;
      d0_3_r <= d0_r;
      d1_3_r <= d1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: hermite basis weights h00, h10, h01 and g11 (h11 = -g11)
  // ---------------------------------------------------------------------------
  logic [H_W-1:0]       w00;
  logic [H_W-1:0]       w01;
  logic [H_W+T_W-1:0]   m00;
  logic [H_W+T_W-1:0]   m01;
  logic [2*T_W-1:0]     m10;
  logic [2*T_W-1:0]     m11;
  logic [H_W-1:0]       h00_r;
  logic [H_W-1:0]       h10_r;
  logic [H_W-1:0]       h01_r;
  logic [H_W-1:0]       g11_r;
  val_t                 v0_4_r;
  val_t                 v1_4_r;
  slope_t               d0_4_r;
  slope_t               d1_4_r;

  always_comb begin
    w00 = H_W'(FRAC_ONE) + {t3_r, 1'b0};
    w01 = THREE_ONE - {t3_r, 1'b0};
    m00 = (H_W + T_W)'(w00) * (H_W + T_W)'(uu3_r);
    m01 = (H_W + T_W)'(w01) * (H_W + T_W)'(tt3_r);
    m10 = (2 * T_W)'(t3_r) * (2 * T_W)'(uu3_r);
    m11 = (2 * T_W)'(tt3_r) * (2 * T_W)'(u3_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      h00_r  <= m00[FRAC_BITS +: H_W];
      h01_r  <= m01[FRAC_BITS +: H_W];
      h10_r  <= m10[FRAC_BITS +: H_W];
      g11_r  <= m11[FRAC_BITS +: H_W];
      v0_4_r <= v0_3_r;
      v1_4_r <= v1_3_r;
      d0_4_r <= d0_3_r;
      d1_4_r <= d1_3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: weight times rom entry
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p00_r;
  logic signed [PROD_W-1:0] p10_r;
  logic signed [PROD_W-1:0] p01_r;
  logic signed [PROD_W-1:0] p11_r;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      p00_r <= PROD_W'($signed({1'b0, h00_r})) * PROD_W'(v0_4_r);
      p10_r <= PROD_W'($signed({1'b0, h10_r})) * PROD_W'(d0_4_r);
      p01_r <= PROD_W'($signed({1'b0, h01_r})) * PROD_W'(v1_4_r);
      p11_r <= PROD_W'($signed({1'b0, g11_r})) * PROD_W'(d1_4_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: pairwise sums, rounding offset folded into the first
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] sa_r;
  logic signed [ACC_W-1:0] sb_r;

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      sa_r <= ACC_W'(p00_r) + ACC_W'(p10_r) + RND_OUT;
      sb_r <= ACC_W'(p01_r) - ACC_W'(p11_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: final sum, floor shift back to q1.14, saturate; output register
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [RES_W-1:0] res_c;
  out_data_t               res_sat;
  out_data_t               res_r;

  always_comb begin
    acc_sum = sa_r + sb_r;
    acc_sh  = acc_sum >>> OUT_SHIFT;
    res_c   = acc_sh[RES_W-1:0];
    if (res_c > RES_W'(SAT_ONE)) begin
      res_sat = out_data_t'(SAT_ONE);
    end else if (res_c < -RES_W'(SAT_ONE)) begin
      res_sat = -out_data_t'(SAT_ONE);
    end else begin
      res_sat = res_c[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      res_r <= res_sat;
    end
  end

  assign out_ch.valid    = vld_r[STAGES-1];
  assign out_ch.tanh_out = res_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `TTHI_ASSERT_IMP(a_idx_in_range, vld_r[1], idx1_r <= IDX_W'(TABLE_ENTRIES - 2), "index past last interval")
  `TTHI_ASSERT_IMP(a_frac_split, vld_r[1], (t1_r <= FRAC_ONE) && ((t1_r + u1_r) == FRAC_ONE), "t and u do not split one")
  `TTHI_ASSERT_NXT(a_rom_hold, vld_r[2] && !stage_en[2], vld_r[2] && $stable(v0_r) && $stable(d1_r), "rom data lost in stall")
  `TTHI_ASSERT_IMP(a_out_range, out_ch.valid, (res_r <= out_data_t'(SAT_ONE)) && (res_r >= -out_data_t'(SAT_ONE)), "result outside -1..1")

endmodule
